// ----- src/fvcc_pkg.sv -----
package fvcc_pkg;

  // Fixed-point formats
  localparam int FRAC_BITS    = 12;
  localparam int PHASE_BITS   = 12;
  localparam int CORDIC_STEPS = 28;

  localparam int AMP_W   = FRAC_BITS + 1;
  localparam int SUM_W   = 2 * FRAC_BITS;
  localparam int CW      = 33;
  localparam int MIX_W   = PHASE_BITS + 6;
  localparam int SEG_D_W = PHASE_BITS - 1;

  // Pipeline depths
  localparam int ANGLE_LAT = CORDIC_STEPS + 2;
  localparam int SQRT_LAT  = FRAC_BITS + 2;
  localparam int MAG_PAD   = ANGLE_LAT - SQRT_LAT;
  localparam int MIX_LAT   = 4;
  localparam int TOTAL_LAT = ANGLE_LAT + MIX_LAT;

  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  // Channel codes
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  // Quadrant flags that ride along the angle pipeline
  typedef struct packed {
    logic x_zero;
    logic x_neg;
    logic y_zero;
    logic y_neg;
  } quad_t;

  // atan(2^-i) with one turn = 2^32
  localparam logic [31:0] STEP_ANGLE [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005
  };

  // Eighth of a turn to wheel segment
  function automatic logic [2:0] seg_of(input logic [2:0] eighth);
    logic [2:0] s;
    case (eighth) inside
      3'd0: s = 3'd0;
      3'd1: s = 3'd1;
      3'd2: s = 3'd2;
      3'd3: s = 3'd3;
      3'd4, 3'd5: s = 3'd4;
      default: s = 3'd5;
    endcase
    return s;
  endfunction

  function automatic logic [2:0] seg_start(input logic [2:0] seg);
    logic [2:0] s;
    case (seg)
      3'd0: s = 3'd0;
      3'd1: s = 3'd1;
      3'd2: s = 3'd2;
      3'd3: s = 3'd3;
      3'd4: s = 3'd4;
      default: s = 3'd6;
    endcase
    return s;
  endfunction

  // Segment start color
  function automatic logic [7:0] color_from(input logic [2:0] seg, input logic [1:0] ch);
    logic [7:0] r, g, b, v;
    case (seg)
      3'd0: begin r = 8'd255; g = 8'd0;   b = 8'd0;   end
      3'd1: begin r = 8'd255; g = 8'd0;   b = 8'd255; end
      3'd2: begin r = 8'd64;  g = 8'd64;  b = 8'd255; end
      3'd3: begin r = 8'd0;   g = 8'd255; b = 8'd255; end
      3'd4: begin r = 8'd0;   g = 8'd255; b = 8'd0;   end
      default: begin r = 8'd255; g = 8'd255; b = 8'd0; end
    endcase
    case (ch)
      CH_RED:   v = r;
      CH_GREEN: v = g;
      default:  v = b;
    endcase
    return v;
  endfunction

  // Segment end color
  function automatic logic [7:0] color_to(input logic [2:0] seg, input logic [1:0] ch);
    logic [7:0] r, g, b, v;
    case (seg)
      3'd0: begin r = 8'd255; g = 8'd0;   b = 8'd255; end
      3'd1: begin r = 8'd64;  g = 8'd64;  b = 8'd255; end
      3'd2: begin r = 8'd0;   g = 8'd255; b = 8'd255; end
      3'd3: begin r = 8'd0;   g = 8'd255; b = 8'd0;   end
      3'd4: begin r = 8'd255; g = 8'd255; b = 8'd0;   end
      default: begin r = 8'd255; g = 8'd0; b = 8'd0; end
    endcase
    case (ch)
      CH_RED:   v = r;
      CH_GREEN: v = g;
      default:  v = b;
    endcase
    return v;
  endfunction

endpackage

// ----- src/flow_vector_color_coder.sv -----
// Flow vector color coder: one flow word (flow_x, flow_y) per clock in, one
// RGB word out per accepted word, in order. The angle path is an entry stage,
// the 28-step CORDIC pipeline and a quadrant stage; the color path then
// registers segment lookup, blend, magnitude multiply and scale in turn. The
// magnitude path (squares, sum, one square-root bit per stage) runs alongside
// and is delayed to match. busy stays low, so a word is accepted on every clock
// with start high. done marks the result on red/green/blue for that one cycle
// only; the receiver must take it then, since there is no way to hold it.
module flow_vector_color_coder (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] flow_x,
  input  logic signed [15:0] flow_y,
  output logic               done,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue
);
  import fvcc_pkg::*;

  logic [31:0]        turn;
  logic [AMP_W-1:0]   amp;
  logic [TOTAL_LAT-1:0] vld;

  assign busy = 1'b0;

  fvcc_angle u_angle (
    .clk    (clk),
    .flow_x (flow_x),
    .flow_y (flow_y),
    .turn   (turn)
  );

  fvcc_mag u_mag (
    .clk    (clk),
    .flow_x (flow_x),
    .flow_y (flow_y),
    .amp    (amp)
  );

  fvcc_mix u_mix (
    .clk   (clk),
    .turn  (turn),
    .amp   (amp),
    .red   (red),
    .green (green),
    .blue  (blue)
  );

  // Valid bits follow the words through the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[TOTAL_LAT-2:0], start & ~busy};
    end
  end

  assign done = vld[TOTAL_LAT-1];

  a_done_has_word: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, TOTAL_LAT))
    else $error("result without an accepted word");

  a_word_gives_done: assert property (@(posedge clk) disable iff (rst)
    start |-> ##TOTAL_LAT done)
    else $error("accepted word produced no result");

  a_zero_is_black: assert property (@(posedge clk) disable iff (rst)
    (done && $past(flow_x == 16'sd0 && flow_y == 16'sd0, TOTAL_LAT))
      |-> (red == 8'd0 && green == 8'd0 && blue == 8'd0))
    else $error("zero vector gave nonzero color");

endmodule

// ----- src/fvcc_mag.sv -----
module fvcc_mag (
  input  logic                          clk,
  input  logic signed [15:0]            flow_x,
  input  logic signed [15:0]            flow_y,
  output logic [fvcc_pkg::AMP_W-1:0]    amp
);
  import fvcc_pkg::*;

  logic signed [31:0] px, py;
  logic [30:0]        sq_x, sq_y;
  logic [31:0]        sum;
  logic [SUM_W-1:0]   rem  [FRAC_BITS+1];
  logic [SUM_W-1:0]   root [FRAC_BITS+1];
  logic               over [FRAC_BITS+1];
  logic [AMP_W-1:0]   amp_raw;
  logic [AMP_W-1:0]   dly  [MAG_PAD];

  // Squares
  assign px = 32'(flow_x) * 32'(flow_x);
  assign py = 32'(flow_y) * 32'(flow_y);

  always_ff @(posedge clk) begin
    sq_x <= px[30:0];
    sq_y <= py[30:0];
  end

  // Sum and saturation check
  assign sum = {1'b0, sq_x} + {1'b0, sq_y};

  always_ff @(posedge clk) begin
    over[0] <= (sum >= (32'd1 << SUM_W));
    rem[0]  <= sum[SUM_W-1:0];
    root[0] <= '0;
  end

  // One root bit per stage
  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_root
    localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2 * k);
    logic [SUM_W-1:0] trial;
    assign trial = root[k] + BIT;
    always_ff @(posedge clk) begin
      over[k+1] <= over[k];
      if (rem[k] >= trial) begin
        rem[k+1]  <= rem[k] - trial;
        root[k+1] <= (root[k] >> 1) + BIT;
      end else begin
        rem[k+1]  <= rem[k];
        root[k+1] <= root[k] >> 1;
      end
    end
  end

  assign amp_raw = over[FRAC_BITS] ? (AMP_W'(1) << FRAC_BITS)
                                   : {1'b0, root[FRAC_BITS][FRAC_BITS-1:0]};

  // Delay to line up with the angle
  always_ff @(posedge clk) begin
    dly[0] <= amp_raw;
  end
  for (genvar j = 1; j < MAG_PAD; j++) begin : g_pad
    always_ff @(posedge clk) begin
      dly[j] <= dly[j-1];
    end
  end

  assign amp = dly[MAG_PAD-1];

endmodule

// ----- src/fvcc_angle.sv -----
module fvcc_angle (
  input  logic               clk,
  input  logic signed [15:0] flow_x,
  input  logic signed [15:0] flow_y,
  output logic [31:0]        turn
);
  import fvcc_pkg::*;

  logic [15:0]          ax, ay;
  logic signed [CW-1:0] xs [CORDIC_STEPS+1];
  logic signed [CW-1:0] ys [CORDIC_STEPS+1];
  logic signed [CW-1:0] zs [CORDIC_STEPS+1];
  quad_t                q  [CORDIC_STEPS+1];
  logic [31:0]          a;
  logic signed [CW-1:0] zf;

  // Magnitudes of the components
  assign ax = flow_x[15] ? 16'(-flow_x) : 16'(flow_x);
  assign ay = flow_y[15] ? 16'(-flow_y) : 16'(flow_y);

  always_ff @(posedge clk) begin
    xs[0] <= $signed({3'b000, ax, 14'd0});
    ys[0] <= $signed({3'b000, ay, 14'd0});
    zs[0] <= '0;
    q[0].x_zero <= (flow_x == 16'sd0);
    q[0].x_neg  <= flow_x[15];
    q[0].y_zero <= (flow_y == 16'sd0);
    q[0].y_neg  <= flow_y[15];
  end

  // Vectoring rotations, one per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [CW-1:0] ANG = $signed({1'b0, STEP_ANGLE[i]});
    logic signed [CW-1:0] dx, dy;
    assign dx = ys[i] >>> i;
    assign dy = xs[i] >>> i;
    always_ff @(posedge clk) begin
      q[i+1] <= q[i];
      if (!ys[i][CW-1]) begin
        xs[i+1] <= xs[i] + dx;
        ys[i+1] <= ys[i] - dy;
        zs[i+1] <= zs[i] + ANG;
      end else begin
        xs[i+1] <= xs[i] - dx;
        ys[i+1] <= ys[i] + dy;
        zs[i+1] <= zs[i] - ANG;
      end
    end
  end

  // Clamp to the first quadrant, then mirror
  assign zf = zs[CORDIC_STEPS];

  always_comb begin
    if (q[CORDIC_STEPS].y_zero || zf[CW-1]) begin
      a = '0;
    end else if (zf > $signed({1'b0, QUARTER_TURN})) begin
      a = QUARTER_TURN;
    end else begin
      a = zf[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (q[CORDIC_STEPS].x_zero) begin
      turn <= q[CORDIC_STEPS].y_neg ? 32'(3 * QUARTER_TURN) : QUARTER_TURN;
    end else if (!q[CORDIC_STEPS].x_neg && !q[CORDIC_STEPS].y_neg) begin
      turn <= a;
    end else if (!q[CORDIC_STEPS].y_neg) begin
      turn <= 32'(2 * QUARTER_TURN) - a;
    end else if (q[CORDIC_STEPS].x_neg) begin
      turn <= 32'(2 * QUARTER_TURN) + a;
    end else begin
      turn <= 32'd0 - a;
    end
  end

endmodule

// ----- src/fvcc_mix.sv -----
module fvcc_mix (
  input  logic                          clk,
  input  logic [31:0]                   turn,
  input  logic [fvcc_pkg::AMP_W-1:0]    amp,
  output logic [7:0]                    red,
  output logic [7:0]                    green,
  output logic [7:0]                    blue
);
  import fvcc_pkg::*;

  localparam logic [SEG_D_W-1:0] E = SEG_D_W'(1) << (PHASE_BITS - 3);
  localparam int SHIFT = FRAC_BITS + PHASE_BITS - 3;

  logic [PHASE_BITS-1:0] phase, full_d;
  logic [2:0]            seg0;
  logic [2:0]            seg1;
  logic [SEG_D_W-1:0]    d1, w1, wd1;
  logic                  wide1, wide2, wide3;
  logic [AMP_W-1:0]      amp1, amp2;
  logic [MIX_W-1:0]      mix2 [3];
  logic [AMP_W+MIX_W-1:0] prod3 [3];
  logic [7:0]            chan [3];

  // Segment and offset into it
  assign phase  = turn[31 -: PHASE_BITS];
  assign seg0   = seg_of(phase[PHASE_BITS-1 -: 3]);
  assign full_d = phase - (PHASE_BITS'(seg_start(seg0)) << (PHASE_BITS - 3));

  always_ff @(posedge clk) begin
    seg1  <= seg0;
    d1    <= full_d[SEG_D_W-1:0];
    wide1 <= (seg0 == 3'd4) || (seg0 == 3'd5);
    amp1  <= amp;
  end

  assign w1  = wide1 ? (E << 1) : E;
  assign wd1 = w1 - d1;

  // Blend, multiply by magnitude, scale and clamp per channel
  for (genvar c = 0; c < 3; c++) begin : g_ch
    logic [AMP_W+MIX_W-1:0] v;
    always_ff @(posedge clk) begin
      mix2[c] <= MIX_W'(color_from(seg1, 2'(c))) * MIX_W'(wd1)
               + MIX_W'(color_to(seg1, 2'(c))) * MIX_W'(d1);
    end
    always_ff @(posedge clk) begin
      prod3[c] <= (AMP_W + MIX_W)'(amp2) * (AMP_W + MIX_W)'(mix2[c]);
    end
    assign v = wide3 ? (prod3[c] >> (SHIFT + 1)) : (prod3[c] >> SHIFT);
    always_ff @(posedge clk) begin
      chan[c] <= (v > (AMP_W + MIX_W)'(255)) ? 8'd255 : v[7:0];
    end
  end

  always_ff @(posedge clk) begin
    amp2  <= amp1;
    wide2 <= wide1;
    wide3 <= wide2;
  end

  assign red   = chan[0];
  assign green = chan[1];
  assign blue  = chan[2];

endmodule

// ----- dv/flow_vector_color_checker.sv -----
`timescale 1ns / 1ps

module flow_vector_color_checker
  import fvcc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [15:0] flow_x,
  input  logic signed [15:0] flow_y,
  input  logic               done,
  input  logic [7:0]         red,
  input  logic [7:0]         green,
  input  logic [7:0]         blue,
  output int                 fail_count,
  output int                 pending
);

  typedef struct {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pixel_t;

  pixel_t expected_pixels[$];

  // wheel end colors per segment, packed r,g,b
  localparam logic [23:0] WHEEL_FROM [6] = '{
    24'hFF0000, 24'hFF00FF, 24'h4040FF, 24'h00FFFF, 24'h00FF00, 24'hFFFF00};
  localparam logic [23:0] WHEEL_TO [6] = '{
    24'hFF00FF, 24'h4040FF, 24'h00FFFF, 24'h00FF00, 24'hFFFF00, 24'hFF0000};

  function automatic longint asr_floor(longint v, int k);
    return v >>> k;
  endfunction

  // first-quadrant binary angle by vectoring rotation
  function automatic longint quad_angle(longint ax, longint ay);
    longint cx, cy, cz, dx, dy;
    if (ay == 0) return 0;
    if (ax == 0) return longint'(QUARTER_TURN);
    cx = ax <<< 14;
    cy = ay <<< 14;
    cz = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = asr_floor(cy, i);
      dy = asr_floor(cx, i);
      if (cy >= 0) begin
        cx += dx; cy -= dy; cz += longint'(STEP_ANGLE[i]);
      end else begin
        cx -= dx; cy += dy; cz -= longint'(STEP_ANGLE[i]);
      end
    end
    if (cz < 0) cz = 0;
    if (cz > longint'(QUARTER_TURN)) cz = longint'(QUARTER_TURN);
    return cz;
  endfunction

  function automatic longint int_sqrt(longint s);
    longint r;
    for (int b = 31; b >= 0; b--)
      if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= s)
        r += longint'(1) << b;
    return r;
  endfunction

  function automatic pixel_t color_code(logic signed [15:0] fx, logic signed [15:0] fy);
    longint x, y, s, one, amp, a, turn, mix, v;
    int p, e, seg, d, w, eighth;
    logic [23:0] cf, ct;
    logic [7:0] ch [3];
    pixel_t px;
    x = fx;
    y = fy;
    s = x * x + y * y;
    one = longint'(1) << FRAC_BITS;
    amp = (s >= one * one) ? one : int_sqrt(s);
    if (x == 0) begin
      turn = (y >= 0) ? longint'(QUARTER_TURN) : 3 * longint'(QUARTER_TURN);
    end else begin
      a = quad_angle(x < 0 ? -x : x, y < 0 ? -y : y);
      if (x > 0 && y >= 0) turn = a;
      else if (x < 0 && y >= 0) turn = 2 * longint'(QUARTER_TURN) - a;
      else if (x < 0) turn = 2 * longint'(QUARTER_TURN) + a;
      else turn = (longint'(1) << 32) - a;
    end
    turn &= 64'hFFFF_FFFF;
    p = int'(turn >> (32 - PHASE_BITS));
    e = 1 << (PHASE_BITS - 3);
    eighth = (p >> (PHASE_BITS - 3)) & 7;
    seg = (eighth < 4) ? eighth : (eighth < 6 ? 4 : 5);
    d = p - ((seg == 5) ? 6 : seg) * e;
    w = ((seg >= 4) ? 2 : 1) * e;
    cf = WHEEL_FROM[seg];
    ct = WHEEL_TO[seg];
    for (int c = 0; c < 3; c++) begin
      mix = longint'(cf[23 - 8*c -: 8]) * (w - d) + longint'(ct[23 - 8*c -: 8]) * d;
      v = (amp * mix) / (longint'(w) << FRAC_BITS);
      if (v > 255) v = 255;
      ch[c] = v[7:0];
    end
    px.r = ch[0];
    px.g = ch[1];
    px.b = ch[2];
    return px;
  endfunction

  assign pending = expected_pixels.size();

  // predict on accepted words, compare on strobed results
  always @(posedge clk) begin
    pixel_t want;
    if (!rst) begin
      if (done) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected word r=%0d g=%0d b=%0d", $time, red, green, blue);
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (red !== want.r) begin
            $display("%0t: red expected %0d actual %0d", $time, want.r, red);
            fail_count++;
          end
          if (green !== want.g) begin
            $display("%0t: green expected %0d actual %0d", $time, want.g, green);
            fail_count++;
          end
          if (blue !== want.b) begin
            $display("%0t: blue expected %0d actual %0d", $time, want.b, blue);
            fail_count++;
          end
        end
      end
      if (start && !busy) expected_pixels.push_back(color_code(flow_x, flow_y));
    end
  end

  initial fail_count = 0;

endmodule

// ----- dv/flow_vector_color_coder_test.sv -----
`timescale 1ns / 1ps

module flow_vector_color_coder_test;
  import fvcc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_WORDS   = 1150;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic signed [15:0] flow_x;
  logic signed [15:0] flow_y;
  logic               done;
  logic [7:0]         red, green, blue;
  int                 fail_count;
  int                 pending;
  int                 idle_cycles;

  flow_vector_color_coder dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .flow_x(flow_x),
    .flow_y(flow_y), .done(done), .red(red), .green(green), .blue(blue)
  );

  flow_vector_color_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .flow_x(flow_x),
    .flow_y(flow_y), .done(done), .red(red), .green(green), .blue(blue),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // watchdog on cycles with no accepted word either way
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // hold one word until accepted, then drop start for a random gap
  task automatic send_word(logic signed [15:0] fx, logic signed [15:0] fy, bit gap_ok);
    int gap;
    start  <= 1'b1;
    flow_x <= fx;
    flow_y <= fy;
    @(posedge clk);
    while (busy) @(posedge clk);
    gap = 0;
    if (gap_ok) begin
      case ($urandom_range(0, 9))
        0, 1, 2: gap = $urandom_range(1, 3);
        3:       gap = $urandom_range(10, 60);
        default: gap = 0;
      endcase
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic random_vector(output logic signed [15:0] fx, output logic signed [15:0] fy);
    int kind;
    kind = $urandom_range(0, 9);
    fx = 16'($urandom);
    fy = 16'($urandom);
    if (kind < 4) begin
      // within the unclamped magnitude range
      fx = 16'($signed(12'($urandom)) >>> $urandom_range(0, 4));
      fy = 16'($signed(12'($urandom)) >>> $urandom_range(0, 4));
    end else if (kind == 4) begin
      fx = '0;
    end else if (kind == 5) begin
      fy = '0;
    end else if (kind == 6) begin
      fx = 16'($urandom_range(1, 4000));
      fy = -$signed(16'($urandom_range(1, 3)));
    end
  endtask

  initial begin
    logic signed [15:0] fx, fy;
    rst    <= 1'b1;
    start  <= 1'b0;
    flow_x <= '0;
    flow_y <= '0;
    idle_cycles = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: zero, axes, extremes, diagonals, near-wrap below +x
    send_word(16'sd0, 16'sd0, 1'b0);
    send_word(16'sd0, 16'sd4096, 1'b0);
    send_word(16'sd0, -16'sd4096, 1'b0);
    send_word(16'sd4096, 16'sd0, 1'b0);
    send_word(-16'sd4096, 16'sd0, 1'b0);
    send_word(16'sd0, 16'sd5, 1'b0);
    send_word(16'sd7, 16'sd0, 1'b0);
    send_word(16'sd32767, 16'sd32767, 1'b0);
    send_word(-16'sd32768, -16'sd32768, 1'b0);
    send_word(16'sd32767, -16'sd32768, 1'b0);
    send_word(-16'sd32768, 16'sd32767, 1'b0);
    send_word(16'sd2896, 16'sd2896, 1'b0);
    send_word(-16'sd2896, 16'sd2896, 1'b0);
    send_word(-16'sd2896, -16'sd2896, 1'b0);
    send_word(16'sd2896, -16'sd2896, 1'b0);
    send_word(16'sd4000, -16'sd1, 1'b0);
    send_word(16'sd32767, -16'sd1, 1'b0);
    send_word(16'sd1, 16'sd1, 1'b0);
    send_word(-16'sd1, -16'sd1, 1'b0);
    send_word(16'sd4095, 16'sd1, 1'b0);
    send_word(16'sd2048, 16'sd3547, 1'b1);

    // random words; drain fully once midway
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      random_vector(fx, fy);
      send_word(fx, fy, n > 50);
      if (n == RANDOM_WORDS / 2) begin
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
    end
    start <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TOTAL_LAT + 10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
